@@ hw/rtl/midpoint_line_rasterizer_macros.svh @@
// Assertion macros used by the line rasterizer checker.
`ifndef MIDPOINT_LINE_RASTERIZER_MACROS_SVH
`define MIDPOINT_LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MLR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("line rasterizer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MLR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("line rasterizer check failed");

`endif

@@ hw/rtl/mlr_pkg.sv @@
// Shared types and constants of the midpoint line rasterizer.
`default_nettype none

package mlr_pkg;

    localparam int COORD_BITS_DEFAULT = 12;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Reflection applied to fold the line into a walk with rising major axis.
    typedef enum logic [2:0] {
        MODE_SHALLOW_UP   = 3'd0,
        MODE_STEEP_UP     = 3'd1,
        MODE_SHALLOW_DOWN = 3'd2,
        MODE_STEEP_DOWN   = 3'd3,
        MODE_VERTICAL     = 3'd4
    } mlr_mode_t;

    typedef struct packed {
        mlr_mode_t mode;
        logic      active;
        logic      first_pending;
    } mlr_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/mlr_if.sv @@
// Valid/ready channel interfaces for line commands and pixels.
`default_nettype none

interface mlr_cmd_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;

    modport source (output valid, output op, output x_start, output y_start,
                    output x_end, output y_end, input ready);
    modport sink (input valid, input op, input x_start, input y_start,
                  input x_end, input y_end, output ready);
endinterface

interface mlr_pix_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last;

    modport source (output valid, output pixel_x, output pixel_y, output last,
                    input ready);
    modport sink (input valid, input pixel_x, input pixel_y, input last,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mlr_setup.sv @@
// Line setup: endpoint ordering, octant selection and decision start values.
`default_nettype none

module mlr_setup
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  wire logic [COORD_BITS-1:0]   x_start,
    input  wire logic [COORD_BITS-1:0]   y_start,
    input  wire logic [COORD_BITS-1:0]   x_end,
    input  wire logic [COORD_BITS-1:0]   y_end,
    output      mlr_ctl_t                ctl,
    output      logic signed [COORD_BITS:0]   major_pos,
    output      logic signed [COORD_BITS:0]   minor_pos,
    output      logic signed [COORD_BITS:0]   major_end,
    output      logic signed [COORD_BITS+3:0] decision,
    output      logic signed [COORD_BITS+3:0] step_straight,
    output      logic signed [COORD_BITS+3:0] step_diagonal
);

    localparam int WORK_BITS = COORD_BITS + 2;
    localparam int DEC_BITS  = COORD_BITS + 4;

    logic                        swap;
    logic                        vertical;
    logic signed [WORK_BITS-1:0] sx, sy, ex, ey;
    logic signed [WORK_BITS-1:0] x0, y0, x1, y1;
    logic signed [WORK_BITS-1:0] dx, dy;
    logic signed [WORK_BITS-1:0] mx0, my0, mx1, my1;
    logic signed [DEC_BITS-1:0]  a, b;
    mlr_mode_t                   mode;

    assign sx = signed'({2'b00, x_start});
    assign sy = signed'({2'b00, y_start});
    assign ex = signed'({2'b00, x_end});
    assign ey = signed'({2'b00, y_end});

    assign vertical = (x_start == x_end);
    assign swap     = (x_end < x_start);

    assign x0 = swap ? ex : sx;
    assign y0 = swap ? ey : sy;
    assign x1 = swap ? sx : ex;
    assign y1 = swap ? sy : ey;

    assign dx = x1 - x0;
    assign dy = y1 - y0;

    always_comb
    begin
        if (vertical)
        begin
            mode = MODE_VERTICAL;
        end
        else if (dy >= 0 && dy <= dx)
        begin
            mode = MODE_SHALLOW_UP;
        end
        else if (dy > dx)
        begin
            mode = MODE_STEEP_UP;
        end
        else if (-dy <= dx)
        begin
            mode = MODE_SHALLOW_DOWN;
        end
        else
        begin
            mode = MODE_STEEP_DOWN;
        end
    end

    // Fold the endpoints so the major coordinate rises along the walk.
    always_comb
    begin
        case (mode)
            MODE_STEEP_UP:
            begin
                mx0 = y0;  my0 = x0;  mx1 = y1;  my1 = x1;
            end
            MODE_SHALLOW_DOWN:
            begin
                mx0 = x0;  my0 = -y0; mx1 = x1;  my1 = -y1;
            end
            MODE_STEEP_DOWN:
            begin
                mx0 = -y0; my0 = x0;  mx1 = -y1; my1 = x1;
            end
            MODE_VERTICAL:
            begin
                mx0 = (sy <= ey) ? sy : ey;
                my0 = sx;
                mx1 = (sy <= ey) ? ey : sy;
                my1 = sx;
            end
            default:
            begin
                mx0 = x0;  my0 = y0;  mx1 = x1;  my1 = y1;
            end
        endcase
    end

    assign a = DEC_BITS'(my0) - DEC_BITS'(my1);
    assign b = DEC_BITS'(mx1) - DEC_BITS'(mx0);

    assign major_pos = mx0[COORD_BITS:0];
    assign minor_pos = my0[COORD_BITS:0];
    assign major_end = mx1[COORD_BITS:0];

    assign decision      = vertical ? '0 : (a <<< 1) + b;
    assign step_straight = vertical ? '0 : (a <<< 1);
    assign step_diagonal = vertical ? '0 : ((a + b) <<< 1);

    assign ctl.mode          = mode;
    assign ctl.active        = !(vertical && (y_start == y_end));
    assign ctl.first_pending = !(vertical && (y_start == y_end));

endmodule

`default_nettype wire

@@ hw/rtl/mlr_step.sv @@
// Walk step: advances the folded position and unfolds it to a pixel.
`default_nettype none

module mlr_step
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  wire mlr_ctl_t                       ctl,
    input  wire logic signed [COORD_BITS:0]     major_pos,
    input  wire logic signed [COORD_BITS:0]     minor_pos,
    input  wire logic signed [COORD_BITS:0]     major_end,
    input  wire logic signed [COORD_BITS+3:0]   decision,
    input  wire logic signed [COORD_BITS+3:0]   step_straight,
    input  wire logic signed [COORD_BITS+3:0]   step_diagonal,
    output      logic signed [COORD_BITS:0]     major_next,
    output      logic signed [COORD_BITS:0]     minor_next,
    output      logic signed [COORD_BITS+3:0]   decision_next,
    output      logic [COORD_BITS-1:0]          pixel_x,
    output      logic [COORD_BITS-1:0]          pixel_y,
    output      logic                           last
);

    localparam logic signed [COORD_BITS:0] POS_ONE = (COORD_BITS+1)'(1);

    logic signed [COORD_BITS:0] px, py;

    // The first pixel is the start point itself; later ones advance by one.
    always_comb
    begin
        major_next    = major_pos;
        minor_next    = minor_pos;
        decision_next = decision;
        if (!ctl.first_pending)
        begin
            major_next = major_pos + POS_ONE;
            if (ctl.mode != MODE_VERTICAL)
            begin
                if (decision < 0)
                begin
                    minor_next    = minor_pos + POS_ONE;
                    decision_next = decision + step_diagonal;
                end
                else
                begin
                    decision_next = decision + step_straight;
                end
            end
        end
    end

    always_comb
    begin
        unique case (ctl.mode)
            MODE_SHALLOW_UP:
            begin
                px = major_next;  py = minor_next;
            end
            MODE_STEEP_UP:
            begin
                px = minor_next;  py = major_next;
            end
            MODE_SHALLOW_DOWN:
            begin
                px = major_next;  py = -minor_next;
            end
            MODE_STEEP_DOWN:
            begin
                px = minor_next;  py = -major_next;
            end
            MODE_VERTICAL:
            begin
                px = minor_next;  py = major_next;
            end
            default:
            begin
                px = minor_next;  py = major_next;
            end
        endcase
    end

    assign pixel_x = px[COORD_BITS-1:0];
    assign pixel_y = py[COORD_BITS-1:0];
    assign last    = (major_next == major_end);

endmodule

`default_nettype wire

@@ hw/rtl/midpoint_line_rasterizer.sv @@
// Top level of the midpoint line rasterizer: walk state and pixel register.
`default_nettype none

// Midpoint line rasterizer. A load command (op 0) sets up a line from two
// endpoints in the cycle it is transferred and produces no pixel; each step
// command (op 1) then yields the next pixel of that line, from the end with the
// smaller x (smaller y for a vertical line), with last marking the final one.
// Steps while no line is active, and loads of a single point, produce nothing.
// A load during a line abandons it. Commands are taken one per clock: the walk
// state advances by one add and compare per step, and the pixel appears in the
// output register in the cycle after its step is transferred. The command port
// stays ready whenever the output register is empty or being emptied.

module midpoint_line_rasterizer
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mlr_cmd_if.sink   cmd,
    mlr_pix_if.source pix
);

    localparam int DEC_BITS = COORD_BITS + 4;

    mlr_ctl_t                    ctl_reg, ctl_next;
    logic signed [COORD_BITS:0]  major_reg, major_next;
    logic signed [COORD_BITS:0]  minor_reg, minor_next;
    logic signed [COORD_BITS:0]  end_reg, end_next;
    logic signed [DEC_BITS-1:0]  dec_reg, dec_next;
    logic signed [DEC_BITS-1:0]  straight_reg, straight_next;
    logic signed [DEC_BITS-1:0]  diag_reg, diag_next;

    logic                        pix_valid_reg, pix_valid_next;
    logic [COORD_BITS-1:0]       pix_x_reg, pix_x_next;
    logic [COORD_BITS-1:0]       pix_y_reg, pix_y_next;
    logic                        pix_last_reg, pix_last_next;

    mlr_ctl_t                    setup_ctl;
    logic signed [COORD_BITS:0]  setup_major, setup_minor, setup_end;
    logic signed [DEC_BITS-1:0]  setup_dec, setup_straight, setup_diag;

    logic signed [COORD_BITS:0]  walk_major, walk_minor;
    logic signed [DEC_BITS-1:0]  walk_dec;
    logic [COORD_BITS-1:0]       walk_x, walk_y;
    logic                        walk_last;

    logic                        cmd_xfer;
    logic                        do_step;

    mlr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .x_start       (cmd.x_start),
        .y_start       (cmd.y_start),
        .x_end         (cmd.x_end),
        .y_end         (cmd.y_end),
        .ctl           (setup_ctl),
        .major_pos     (setup_major),
        .minor_pos     (setup_minor),
        .major_end     (setup_end),
        .decision      (setup_dec),
        .step_straight (setup_straight),
        .step_diagonal (setup_diag)
    );

    mlr_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .ctl           (ctl_reg),
        .major_pos     (major_reg),
        .minor_pos     (minor_reg),
        .major_end     (end_reg),
        .decision      (dec_reg),
        .step_straight (straight_reg),
        .step_diagonal (diag_reg),
        .major_next    (walk_major),
        .minor_next    (walk_minor),
        .decision_next (walk_dec),
        .pixel_x       (walk_x),
        .pixel_y       (walk_y),
        .last          (walk_last)
    );

    assign cmd.ready = !pix_valid_reg || pix.ready;
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign do_step   = cmd_xfer && (cmd.op == OP_STEP) && ctl_reg.active;

    always_comb
    begin
        ctl_next      = ctl_reg;
        major_next    = major_reg;
        minor_next    = minor_reg;
        end_next      = end_reg;
        dec_next      = dec_reg;
        straight_next = straight_reg;
        diag_next     = diag_reg;
        if (cmd_xfer && (cmd.op == OP_LOAD))
        begin
            ctl_next      = setup_ctl;
            major_next    = setup_major;
            minor_next    = setup_minor;
            end_next      = setup_end;
            dec_next      = setup_dec;
            straight_next = setup_straight;
            diag_next     = setup_diag;
        end
        else if (do_step)
        begin
            ctl_next.first_pending = 1'b0;
            ctl_next.active        = !walk_last;
            major_next             = walk_major;
            minor_next             = walk_minor;
            dec_next               = walk_dec;
        end
    end

    // Output register: loads on a step, clears once its pixel is transferred.
    always_comb
    begin
        pix_valid_next = pix_valid_reg && !pix.ready;
        pix_x_next     = pix_x_reg;
        pix_y_next     = pix_y_reg;
        pix_last_next  = pix_last_reg;
        if (do_step)
        begin
            pix_valid_next = 1'b1;
            pix_x_next     = walk_x;
            pix_y_next     = walk_y;
            pix_last_next  = walk_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= '{mode: MODE_SHALLOW_UP, active: 1'b0, first_pending: 1'b0};
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            ctl_reg       <= ctl_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        major_reg    <= major_next;
        minor_reg    <= minor_next;
        end_reg      <= end_next;
        dec_reg      <= dec_next;
        straight_reg <= straight_next;
        diag_reg     <= diag_next;
        pix_x_reg    <= pix_x_next;
        pix_y_reg    <= pix_y_next;
        pix_last_reg <= pix_last_next;
    end

    assign pix.valid   = pix_valid_reg;
    assign pix.pixel_x = pix_x_reg;
    assign pix.pixel_y = pix_y_reg;
    assign pix.last    = pix_last_reg;

endmodule

`default_nettype wire

@@ hw/rtl/mlr_checker.sv @@
// Port-level checks of the line rasterizer, bound to the top level.
`default_nettype none

`include "midpoint_line_rasterizer_macros.svh"

module mlr_checker
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  cmd_valid,
    input wire logic                  cmd_ready,
    input wire logic                  cmd_op,
    input wire logic                  pix_valid,
    input wire logic                  pix_ready,
    input wire logic [COORD_BITS-1:0] pix_x,
    input wire logic [COORD_BITS-1:0] pix_y,
    input wire logic                  pix_last
);

    // A stalled pixel keeps its value until transferred.
    `MLR_ASSERT_NEXT(a_pix_hold, clk, rst_n, pix_valid && !pix_ready, pix_valid && $stable(pix_x) && $stable(pix_y) && $stable(pix_last))

    // Commands are never refused while the output register is free.
    `MLR_ASSERT_SAME(a_ready_when_free, clk, rst_n, !pix_valid || pix_ready, cmd_ready)

    // A new pixel only follows a transferred step command.
    `MLR_ASSERT_SAME(a_pix_from_step, clk, rst_n, pix_valid && !$past(pix_valid && !pix_ready), $past(cmd_valid && cmd_ready && (cmd_op == OP_STEP)))

    // A load never produces a pixel.
    `MLR_ASSERT_NEXT(a_load_silent, clk, rst_n, cmd_valid && cmd_ready && (cmd_op == OP_LOAD), !pix_valid)

endmodule

bind midpoint_line_rasterizer mlr_checker #(
    .COORD_BITS (COORD_BITS)
) u_mlr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .cmd_op    (cmd.op),
    .pix_valid (pix.valid),
    .pix_ready (pix.ready),
    .pix_x     (pix.pixel_x),
    .pix_y     (pix.pixel_y),
    .pix_last  (pix.last)
);

`default_nettype wire

@@ sim/tb_midpoint_line_rasterizer.sv @@
// Self-checking testbench for the midpoint line rasterizer: directed and random lines.
`timescale 1ns / 100ps

module tb_midpoint_line_rasterizer
    import mlr_pkg::*;
;

    localparam int COORD_BITS  = COORD_BITS_DEFAULT;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 8;

    typedef struct packed {
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic                  last;
    } pixel_t;

    logic clk;
    logic rst_n;

    mlr_cmd_if #(.COORD_BITS(COORD_BITS)) cmd_bus ();
    mlr_pix_if #(.COORD_BITS(COORD_BITS)) pix_bus ();

    midpoint_line_rasterizer #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .pix   (pix_bus)
    );

    // Expected pixels, oldest first
    pixel_t pending_pixels[$];
    int     mismatch_count;
    int     sent_items;
    int     cycle_count;
    bit     steady;

    // Line walk state of the predictor
    bit        line_busy;
    bit        first_due;
    mlr_mode_t walk_mode;
    int        major_at;
    int        minor_at;
    int        major_stop;
    int        err_term;
    int        err_straight;
    int        err_diag;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Folded walk: major axis rises by one per pixel
    function automatic void load_walk(int m0, int n0, int m1, int n1);
        int a;
        int b;
        a = n0 - n1;
        b = m1 - m0;
        major_at     = m0;
        minor_at     = n0;
        major_stop   = m1;
        err_term     = 2 * a + b;
        err_straight = 2 * a;
        err_diag     = 2 * (a + b);
    endfunction

    function automatic void rasterize_cmd(logic op, int xs, int ys, int xe, int ye);
        int x0;
        int y0;
        int x1;
        int y1;
        int dx;
        int dy;
        int px;
        int py;
        pixel_t pix_item;
        if (op == OP_LOAD)
        begin
            line_busy = 1'b0;
            first_due = 1'b0;
            if (xs == xe && ys == ye)
                return;
            if (xs == xe)
            begin
                walk_mode    = MODE_VERTICAL;
                minor_at     = xs;
                major_at     = (ys <= ye) ? ys : ye;
                major_stop   = (ys <= ye) ? ye : ys;
                err_term     = 0;
                err_straight = 0;
                err_diag     = 0;
            end
            else
            begin
                if (xs < xe)
                begin
                    x0 = xs; y0 = ys; x1 = xe; y1 = ye;
                end
                else
                begin
                    x0 = xe; y0 = ye; x1 = xs; y1 = ys;
                end
                dx = x1 - x0;
                dy = y1 - y0;
                if (dy >= 0 && dy <= dx)
                begin
                    walk_mode = MODE_SHALLOW_UP;
                    load_walk(x0, y0, x1, y1);
                end
                else if (dy > dx)
                begin
                    walk_mode = MODE_STEEP_UP;
                    load_walk(y0, x0, y1, x1);
                end
                else if (-dy <= dx)
                begin
                    walk_mode = MODE_SHALLOW_DOWN;
                    load_walk(x0, -y0, x1, -y1);
                end
                else
                begin
                    walk_mode = MODE_STEEP_DOWN;
                    load_walk(-y0, x0, -y1, x1);
                end
            end
            line_busy = 1'b1;
            first_due = 1'b1;
            return;
        end
        if (!line_busy)
            return;
        if (first_due)
        begin
            first_due = 1'b0;
        end
        else
        begin
            major_at = major_at + 1;
            if (walk_mode != MODE_VERTICAL)
            begin
                // tie goes straight
                if (err_term < 0)
                begin
                    minor_at = minor_at + 1;
                    err_term = err_term + err_diag;
                end
                else
                begin
                    err_term = err_term + err_straight;
                end
            end
        end
        case (walk_mode)
            MODE_SHALLOW_UP:
            begin
                px = major_at; py = minor_at;
            end
            MODE_STEEP_UP:
            begin
                px = minor_at; py = major_at;
            end
            MODE_SHALLOW_DOWN:
            begin
                px = major_at; py = -minor_at;
            end
            MODE_STEEP_DOWN:
            begin
                px = minor_at; py = -major_at;
            end
            default:
            begin
                px = minor_at; py = major_at;
            end
        endcase
        pix_item.px   = px[COORD_BITS-1:0];
        pix_item.py   = py[COORD_BITS-1:0];
        pix_item.last = (major_at == major_stop);
        pending_pixels.push_back(pix_item);
        if (major_at == major_stop)
            line_busy = 1'b0;
    endfunction

    // Sends one command and predicts its pixel at the transfer edge
    task automatic send_cmd(input logic op, input int xs, input int ys, input int xe,
                            input int ye);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid   <= 1'b1;
        cmd_bus.op      <= op;
        cmd_bus.x_start <= xs[COORD_BITS-1:0];
        cmd_bus.y_start <= ys[COORD_BITS-1:0];
        cmd_bus.x_end   <= xe[COORD_BITS-1:0];
        cmd_bus.y_end   <= ye[COORD_BITS-1:0];
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        rasterize_cmd(op, xs, ys, xe, ye);
        sent_items++;
    endtask

    // Step payload is ignored, so it carries random bits
    task automatic send_step();
        send_cmd(OP_STEP, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                 $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
    endtask

    task automatic draw_line(input int xs, input int ys, input int xe, input int ye,
                             input int steps);
        send_cmd(OP_LOAD, xs, ys, xe, ye);
        repeat (steps) send_step();
    endtask

    task automatic wait_drained();
        cmd_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_pixels.size() != 0);
    endtask

    function automatic int rand_coord();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? $urandom_range(0, 7)
                                        : COORD_MAX - $urandom_range(0, 7);
        return $urandom_range(0, COORD_MAX);
    endfunction

    function automatic int clamp_coord(int v);
        if (v < 0)
            return 0;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    function automatic int pixel_count(int xs, int ys, int xe, int ye);
        int ax;
        int ay;
        if (xs == xe && ys == ye)
            return 0;
        ax = (xe > xs) ? xe - xs : xs - xe;
        ay = (ye > ys) ? ye - ys : ys - ye;
        return ((ax > ay) ? ax : ay) + 1;
    endfunction

    task automatic random_line();
        int span;
        int xs;
        int ys;
        int xe;
        int ye;
        int dx;
        int dy;
        int n;
        int pick;
        pick = $urandom_range(0, 19);
        span = (pick < 15) ? 16 : (pick < 19) ? 300 : COORD_MAX;
        xs   = rand_coord();
        ys   = rand_coord();
        dx   = $urandom_range(0, 2 * span) - span;
        dy   = $urandom_range(0, 2 * span) - span;
        case ($urandom_range(0, 7))
            0: dx = 0;
            1: dy = 0;
            2: dy = $urandom_range(0, 1) ? dx : -dx;
            default: ;
        endcase
        xe = clamp_coord(xs + dx);
        ye = clamp_coord(ys + dy);
        n  = pixel_count(xs, ys, xe, ye);
        pick = $urandom_range(0, 9);
        if (n > 40)
            n = $urandom_range(1, 40);
        else if (pick < 7)
            n = n + $urandom_range(0, 1);
        else if (pick < 9 && n > 0)
            n = $urandom_range(0, n - 1);
        draw_line(xs, ys, xe, ye, n);
    endtask

    // Pixel sink: random stall before each transfer, none in steady mode
    initial
    begin : pixel_sink
        int stall;
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                pix_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pix_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(pix_bus.valid && pix_bus.ready));
        end
    end

    always @(posedge clk)
    begin : pixel_check
        pixel_t want;
        if (rst_n && pix_bus.valid && pix_bus.ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel x=%0d y=%0d last=%0d", $time,
                         pix_bus.pixel_x, pix_bus.pixel_y, pix_bus.last);
                mismatch_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (pix_bus.pixel_x !== want.px)
                begin
                    $display("%0t: pixel_x expected %0d got %0d", $time, want.px,
                             pix_bus.pixel_x);
                    mismatch_count++;
                end
                if (pix_bus.pixel_y !== want.py)
                begin
                    $display("%0t: pixel_y expected %0d got %0d", $time, want.py,
                             pix_bus.pixel_y);
                    mismatch_count++;
                end
                if (pix_bus.last !== want.last)
                begin
                    $display("%0t: last expected %0d got %0d", $time, want.last,
                             pix_bus.last);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_idle_step();
        send_step();
    endtask

    task automatic test_single_point();
        draw_line(COORD_MAX, 0, COORD_MAX, 0, 1);
    endtask

    task automatic test_octants();
        // diagonal tie, endpoints given high to low
        draw_line(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX - 2, 3);
        draw_line(0, 0, 1, 2, 3);
        draw_line(0, 1, 1, 0, 2);
        draw_line(1, 0, 0, 2, 3);
    endtask

    task automatic test_vertical();
        // walk runs upward from the smaller y; the extra step finds the line done
        draw_line(5, COORD_MAX, 5, COORD_MAX - 1, 3);
    endtask

    task automatic test_reload_busy();
        // abandoned by the next load
        draw_line(0, COORD_MAX, COORD_MAX, 0, 2);
    endtask

    task automatic test_random_lines(input int budget);
        int target;
        target = sent_items + budget;
        while (sent_items < target)
        begin
            if ($urandom_range(0, 9) == 0)
                send_cmd(1'($urandom_range(0, 1)), $urandom_range(0, COORD_MAX),
                         $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                         $urandom_range(0, COORD_MAX));
            else
                random_line();
            if ($urandom_range(0, 39) == 0)
                wait_drained();
        end
    endtask

    task automatic test_drain_pause();
        draw_line(100, 200, 110, 195, 6);
        wait_drained();
        send_step();
        send_step();
        wait_drained();
    endtask

    task automatic test_back_to_back(input int budget);
        steady = 1'b1;
        test_random_lines(budget);
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        cmd_bus.valid   <= 1'b0;
        cmd_bus.op      <= OP_LOAD;
        cmd_bus.x_start <= '0;
        cmd_bus.y_start <= '0;
        cmd_bus.x_end   <= '0;
        cmd_bus.y_end   <= '0;
        mismatch_count = 0;
        sent_items     = 0;
        cycle_count    = 0;
        steady         = 1'b0;
        line_busy      = 1'b0;
        first_due      = 1'b0;
        walk_mode      = MODE_SHALLOW_UP;
        major_at       = 0;
        minor_at       = 0;
        major_stop     = 0;
        err_term       = 0;
        err_straight   = 0;
        err_diag       = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_step();
        test_single_point();
        test_octants();
        test_vertical();
        test_reload_busy();
        test_random_lines(620);
        test_drain_pause();
        test_back_to_back(250);

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
